// ===== rtl/crcfb_pkg.sv =====
`default_nettype none

package crcfb_pkg;

  localparam logic       ACT_START   = 1'b0;
  localparam logic       ACT_PAYLOAD = 1'b1;

  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_COMMAND_ID = 2'd1;
  localparam logic [1:0] REG_SRC_ID     = 2'd2;
  localparam logic [1:0] REG_DST_ID     = 2'd3;

  localparam logic [7:0]  START_BYTE_RST = 8'hA5;
  localparam logic [15:0] COMMAND_ID_RST = 16'h0301;

  localparam logic [7:0]  CRC8_INIT  = 8'hFF;
  localparam logic [7:0]  CRC8_POLY  = 8'h8C;
  localparam logic [15:0] CRC16_INIT = 16'hFFFF;
  localparam logic [15:0] CRC16_POLY = 16'h8408;

  localparam logic [15:0] LEN_OFFSET = 16'd6;

  localparam logic [3:0] IDX_START    = 4'd0;
  localparam logic [3:0] IDX_LEN_LO   = 4'd1;
  localparam logic [3:0] IDX_LEN_HI   = 4'd2;
  localparam logic [3:0] IDX_SEQ      = 4'd3;
  localparam logic [3:0] IDX_CRC8     = 4'd4;
  localparam logic [3:0] IDX_CMD_LO   = 4'd5;
  localparam logic [3:0] IDX_CMD_HI   = 4'd6;
  localparam logic [3:0] IDX_DID_LO   = 4'd7;
  localparam logic [3:0] IDX_DID_HI   = 4'd8;
  localparam logic [3:0] IDX_SND_LO   = 4'd9;
  localparam logic [3:0] IDX_SND_HI   = 4'd10;
  localparam logic [3:0] IDX_RCV_LO   = 4'd11;
  localparam logic [3:0] IDX_RCV_HI   = 4'd12;
  localparam logic [3:0] IDX_TRL_LO   = 4'd1;
  localparam logic [3:0] IDX_TRL_HI   = 4'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] payload_length;
    logic [15:0] data_id;
    logic [7:0] payload_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [15:0] command_id;
    logic [15:0] src_id;
    logic [15:0] dst_id;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } beat_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/crcfb_if.sv =====
`default_nettype none

interface crcfb_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  payload_length;
  logic [15:0] data_id;
  logic [7:0]  payload_byte;

  modport source (output valid, action, payload_length, data_id, payload_byte,
                  input ready);
  modport sink (input valid, action, payload_length, data_id, payload_byte,
                output ready);
endinterface

interface crcfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, out_byte, frame_end, input ready);
  modport sink (input valid, out_byte, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/crcfb_in_stage.sv =====
`default_nettype none

module crcfb_in_stage
  import crcfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  crcfb_in_if.sink   in,
  input  wire logic  consume,
  output logic       item_valid,
  output item_t      item
);

  always_comb begin
    in.ready = !item_valid || consume;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in.ready) begin
      item_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.ready && in.valid) begin
      item <= '{action: in.action, payload_length: in.payload_length,
                data_id: in.data_id, payload_byte: in.payload_byte};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crcfb_emitter.sv =====
`default_nettype none

module crcfb_emitter
  import crcfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  item_valid,
  input  wire item_t item,
  input  wire logic  advance,
  output logic       consume,
  output logic       emit_valid,
  output beat_t      emit_beat
);

  logic [3:0]  idx;
  logic [7:0]  seq;
  logic [15:0] crc16;
  logic [7:0]  crc8;
  logic [7:0]  rem;
  logic        open;

  logic        is_start;
  logic        drop;
  logic        last;
  logic        fire;
  logic        crc_update;
  logic [15:0] len;
  logic [7:0]  hdr_byte;

  always_comb begin
    is_start = (item.action == ACT_START);
    len      = {8'h00, item.payload_length} + LEN_OFFSET;

    case (idx)
      IDX_START:  hdr_byte = cfg.start_byte;
      IDX_LEN_LO: hdr_byte = len[7:0];
      IDX_LEN_HI: hdr_byte = len[15:8];
      IDX_SEQ:    hdr_byte = seq;
      IDX_CRC8:   hdr_byte = crc8;
      IDX_CMD_LO: hdr_byte = cfg.command_id[7:0];
      IDX_CMD_HI: hdr_byte = cfg.command_id[15:8];
      IDX_DID_LO: hdr_byte = item.data_id[7:0];
      IDX_DID_HI: hdr_byte = item.data_id[15:8];
      IDX_SND_LO: hdr_byte = cfg.src_id[7:0];
      IDX_SND_HI: hdr_byte = cfg.src_id[15:8];
      IDX_RCV_LO: hdr_byte = cfg.dst_id[7:0];
      IDX_RCV_HI: hdr_byte = cfg.dst_id[15:8];
      default:    hdr_byte = 8'h00;
    endcase

    emit_beat.frame_end = 1'b0;
    if (is_start) begin
      emit_beat.out_byte = hdr_byte;
    end else begin
      case (idx)
        IDX_START:  emit_beat.out_byte = item.payload_byte;
        IDX_TRL_LO: emit_beat.out_byte = crc16[7:0];
        default: begin
          emit_beat.out_byte  = crc16[15:8];
          emit_beat.frame_end = 1'b1;
        end
      endcase
    end

    if (is_start) begin
      drop = (item.payload_length == 8'd0);
      last = (idx == IDX_RCV_HI);
    end else begin
      drop = (idx == IDX_START) && (!open || rem == 8'd0);
      last = (idx == IDX_TRL_HI) || ((idx == IDX_START) && (rem != 8'd1));
    end

    emit_valid = item_valid && !drop;
    fire       = emit_valid && advance;
    consume    = item_valid && (drop || (advance && last));
    crc_update = is_start || (idx == IDX_START);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= IDX_START;
      seq   <= 8'd0;
      crc16 <= CRC16_INIT;
      crc8  <= CRC8_INIT;
      rem   <= 8'd0;
      open  <= 1'b0;
    end else if (fire) begin
      idx <= last ? IDX_START : idx + 4'd1;
      if (crc_update) begin
        crc16 <= crc16_byte((is_start && idx == IDX_START) ? CRC16_INIT : crc16,
                            emit_beat.out_byte);
      end
      if (is_start) begin
        if (idx == IDX_START) begin
          crc8 <= crc8_byte(CRC8_INIT, hdr_byte);
        end else if (idx < IDX_CRC8) begin
          crc8 <= crc8_byte(crc8, hdr_byte);
        end
        if (last) begin
          rem  <= item.payload_length;
          open <= 1'b1;
        end
      end else begin
        if (idx == IDX_START) begin
          rem <= rem - 8'd1;
        end
        if (idx == IDX_TRL_HI) begin
          open <= 1'b0;
          seq  <= seq + 8'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crcfb_out_stage.sv =====
`default_nettype none

module crcfb_out_stage
  import crcfb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  emit_valid,
  input  wire beat_t emit_beat,
  output logic       advance,
  crcfb_out_if.source out
);

  beat_t beat;

  always_comb begin
    advance       = !out.valid || out.ready;
    out.out_byte  = beat.out_byte;
    out.frame_end = beat.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (advance) begin
      out.valid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit_valid) begin
      beat <= emit_beat;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/crc_protected_frame_builder_unit.sv =====
`default_nettype none

// Frame builder with a CRC-8 protected header and a CRC-16 trailer. A start beat
// (action 0, nonzero length) produces 13 output beats, a payload beat produces one,
// and the final payload beat of a frame produces three (the byte, then the CRC-16
// low and high bytes, frame_end on the last). A start beat with zero length, or a
// payload beat with no open frame, produces nothing. A new input beat is taken in
// the cycle its predecessor hands over its last byte, so throughput is one output
// byte per cycle while the receiver is ready, set by the single byte-wide result
// register behind the input register. A nonzero-length start while a frame is open
// abandons that frame without a trailer and reuses the sequence number.
module crc_protected_frame_builder_unit
  import crcfb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  crcfb_in_if.sink         in,
  crcfb_out_if.source      out,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  beat_t emit_beat;
  logic  item_valid;
  logic  consume;
  logic  emit_valid;
  logic  advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte <= START_BYTE_RST;
      cfg.command_id <= COMMAND_ID_RST;
      cfg.src_id     <= 16'd0;
      cfg.dst_id     <= 16'd0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_START_BYTE: cfg.start_byte <= cfg_data[7:0];
        REG_COMMAND_ID: cfg.command_id <= cfg_data;
        REG_SRC_ID:     cfg.src_id     <= cfg_data;
        REG_DST_ID:     cfg.dst_id     <= cfg_data;
        default: ;
      endcase
    end
  end

  crcfb_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in         (in),
    .consume    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  crcfb_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .advance    (advance),
    .consume    (consume),
    .emit_valid (emit_valid),
    .emit_beat  (emit_beat)
  );

  crcfb_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit_beat  (emit_beat),
    .advance    (advance),
    .out        (out)
  );

endmodule

`default_nettype wire

// ===== rtl/crcfb_checker.sv =====
`default_nettype none

module crcfb_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       frame_end
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
    else $error("result beat changed while stalled");

  // nothing leaves straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat valid after reset");

  // a frame end is never followed at once by another frame end
  a_single_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && frame_end |=> !(out_valid && frame_end))
    else $error("two frame ends in a row");

  // with the input idle and the output drained, the block is ready for input
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !in_valid && !out_valid ##1 !in_valid && !out_valid |-> in_ready)
    else $error("input stalled with nothing in flight");

endmodule

bind crc_protected_frame_builder_unit crcfb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in.valid),
  .in_ready  (in.ready),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .out_byte  (out.out_byte),
  .frame_end (out.frame_end)
);

`default_nettype wire

// ===== test/crc_protected_frame_builder_unit_test.sv =====
`timescale 1ns / 100ps

module crc_protected_frame_builder_unit_test;
  import crcfb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class frame_byte_tracker;
    logic [7:0]  start_byte;
    logic [15:0] command_id;
    logic [15:0] src_id;
    logic [15:0] dst_id;
    logic [7:0]  seq_num;
    logic [15:0] frame_crc;
    logic [7:0]  bytes_left;
    bit          frame_open;
    beat_t       bytes_due[$];
    int          errors;

    function new();
      start_byte = START_BYTE_RST;
      command_id = COMMAND_ID_RST;
      src_id     = '0;
      dst_id     = '0;
      seq_num    = '0;
      frame_crc  = CRC16_INIT;
      bytes_left = '0;
      frame_open = 1'b0;
      errors     = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        REG_START_BYTE: start_byte = data[7:0];
        REG_COMMAND_ID: command_id = data;
        REG_SRC_ID:     src_id     = data;
        REG_DST_ID:     dst_id     = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
      return c;
    endfunction

    // body byte: folded into the trailer crc
    function void push_body(logic [7:0] b);
      frame_crc = frame_crc ^ {8'h00, b};
      repeat (8) frame_crc = frame_crc[0] ? ((frame_crc >> 1) ^ CRC16_POLY) : (frame_crc >> 1);
      bytes_due.push_back(beat_t'{out_byte: b, frame_end: 1'b0});
    endfunction

    function void take_item(item_t it);
      logic [15:0] len;
      logic [7:0]  hdr [4];
      logic [7:0]  c8;
      if (it.action == ACT_START) begin
        if (it.payload_length == 8'd0) return;
        len = LEN_OFFSET + {8'h00, it.payload_length};
        hdr = '{start_byte, len[7:0], len[15:8], seq_num};
        c8 = CRC8_INIT;
        frame_crc = CRC16_INIT;
        foreach (hdr[i]) begin
          c8 = crc8_step(c8, hdr[i]);
          push_body(hdr[i]);
        end
        push_body(c8);
        push_body(command_id[7:0]);
        push_body(command_id[15:8]);
        push_body(it.data_id[7:0]);
        push_body(it.data_id[15:8]);
        push_body(src_id[7:0]);
        push_body(src_id[15:8]);
        push_body(dst_id[7:0]);
        push_body(dst_id[15:8]);
        bytes_left = it.payload_length;
        frame_open = 1'b1;
      end else if (frame_open && bytes_left != 8'd0) begin
        push_body(it.payload_byte);
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) begin
          bytes_due.push_back(beat_t'{out_byte: frame_crc[7:0], frame_end: 1'b0});
          bytes_due.push_back(beat_t'{out_byte: frame_crc[15:8], frame_end: 1'b1});
          frame_open = 1'b0;
          seq_num = seq_num + 8'd1;
        end
      end
    endfunction

    function void match_beat(beat_t got);
      beat_t want;
      if (bytes_due.size() == 0) begin
        $display("%0t unexpected beat: expected none, actual byte %02h end %0b",
                 $time, got.out_byte, got.frame_end);
        errors++;
        return;
      end
      want = bytes_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t out_byte mismatch: expected %02h, actual %02h",
                 $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $display("%0t frame_end mismatch: expected %0b, actual %0b",
                 $time, want.frame_end, got.frame_end);
        errors++;
      end
    endfunction

    function bit busy();
      return bytes_due.size() != 0;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  crcfb_in_if  in_if ();
  crcfb_out_if out_if ();

  crc_protected_frame_builder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in        (in_if),
    .out       (out_if),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  frame_byte_tracker frames;
  int cycles = 0;
  int burst_left = 0;
  int framed_items = 0;
  bit idle_gaps = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("crc_protected_frame_builder_unit regression: fail");
      $finish;
    end
  end

  // receiver: ready odds sweep from heavy stalling to always ready
  always @(posedge clk) begin
    if (!rst && out_if.valid === 1'b1 && out_if.ready)
      frames.match_beat(beat_t'{out_byte: out_if.out_byte, frame_end: out_if.frame_end});
    out_if.ready <= ($urandom_range(0, 15) <= cycles[9:6]);
  end

  task automatic send_item(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = idle_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid          <= 1'b1;
    in_if.action         <= it.action;
    in_if.payload_length <= it.payload_length;
    in_if.data_id        <= it.data_id;
    in_if.payload_byte   <= it.payload_byte;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    frames.take_item(it);
  endtask

  // start beat, then payload_beats payload beats (fewer than plen leaves the frame open)
  task automatic send_frame(input int plen, input int payload_beats);
    send_item(item_t'{ACT_START, 8'(plen), 16'($urandom), 8'($urandom)});
    for (int i = 0; i < payload_beats; i++)
      send_item(item_t'{ACT_PAYLOAD, 8'($urandom), 16'($urandom), 8'($urandom)});
    framed_items += 1 + payload_beats;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (frames.busy()) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] sof, input logic [15:0] cmd,
                              input logic [15:0] snd, input logic [15:0] rcv);
    logic [1:0]  idx [4];
    logic [15:0] vals [4];
    idx  = '{REG_START_BYTE, REG_COMMAND_ID, REG_SRC_ID, REG_DST_ID};
    vals = '{{8'h00, sof}, cmd, snd, rcv};
    for (int i = 0; i < 4; i++) begin
      cfg_wen   <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      frames.set_reg(idx[i], vals[i]);
    end
    cfg_wen <= 1'b0;
  endtask

  task automatic run_phase(input int quota);
    int target;
    int r;
    int plen;
    target = framed_items + quota;
    while (framed_items < target) begin
      r = $urandom_range(0, 99);
      plen = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 40);
      if (r < 75)
        send_frame(plen, plen);
      else if (r < 85)
        send_frame(plen, $urandom_range(0, plen - 1));
      else if (r < 92)
        send_item(item_t'{ACT_PAYLOAD, 8'($urandom), 16'($urandom), 8'($urandom)});
      else
        send_item(item_t'{ACT_START, 8'd0, 16'($urandom), 8'($urandom)});
    end
  endtask

  initial begin
    frames = new();
    rst                  = 1'b1;
    cfg_wen              = 1'b0;
    cfg_index            = REG_START_BYTE;
    cfg_data             = '0;
    in_if.valid          = 1'b0;
    in_if.action         = ACT_START;
    in_if.payload_length = '0;
    in_if.data_id        = '0;
    in_if.payload_byte   = '0;
    out_if.ready         = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // shortest frame on reset settings, then dropped payload and empty start
    send_frame(1, 1);
    send_item(item_t'{ACT_PAYLOAD, 8'hFF, 16'hFFFF, 8'hFF});
    send_item(item_t'{ACT_START, 8'd0, 16'hFFFF, 8'hFF});
    send_item(item_t'{ACT_START, 8'd2, 16'h0000, 8'h00});
    send_item(item_t'{ACT_PAYLOAD, 8'h00, 16'h0000, 8'h00});
    send_item(item_t'{ACT_PAYLOAD, 8'h00, 16'h0000, 8'hFF});
    // longest length, abandoned by a new start
    send_item(item_t'{ACT_START, 8'd255, 16'hFFFF, 8'hFF});
    send_item(item_t'{ACT_PAYLOAD, 8'h7F, 16'h1234, 8'h5A});
    send_item(item_t'{ACT_PAYLOAD, 8'h80, 16'h8001, 8'hA5});
    send_item(item_t'{ACT_START, 8'd3, 16'h8001, 8'h00});
    send_item(item_t'{ACT_PAYLOAD, 8'h55, 16'hAAAA, 8'h5A});
    send_item(item_t'{ACT_PAYLOAD, 8'hAA, 16'h5555, 8'hA5});
    send_item(item_t'{ACT_PAYLOAD, 8'h01, 16'h7FFE, 8'h01});
    // empty start inside an open frame is ignored
    send_item(item_t'{ACT_START, 8'd1, 16'h00FF, 8'h80});
    send_item(item_t'{ACT_START, 8'd0, 16'hFF00, 8'h7F});
    send_item(item_t'{ACT_PAYLOAD, 8'h00, 16'h0000, 8'hC3});
    send_item(item_t'{ACT_PAYLOAD, 8'h00, 16'h0000, 8'h3C});
    drain();

    program_regs(8'h00, 16'h0000, 16'h0000, 16'h0000);
    idle_gaps = 1'b1;
    run_phase(15);
    drain();

    program_regs(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    idle_gaps = 1'b0;
    run_phase(15);
    drain();

    program_regs(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    idle_gaps = 1'b1;
    run_phase(15);
    drain();

    program_regs(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(15);
    drain();

    if (frames.errors == 0)
      $display("crc_protected_frame_builder_unit regression: pass");
    else
      $display("crc_protected_frame_builder_unit regression: fail");
    $finish;
  end

endmodule
